// ===== hw/rtl/jll_pkg.sv =====
// Shared types, codes and keyword tables for the JSON literal lexer.
package jll_pkg;

    localparam int POS_WIDTH = 16;
    localparam int KW_POS_W  = 3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_UNEXP = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NULL = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_S     = 8'h73;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_MATCH = 2'd1,
        MODE_AWAIT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KW_NULL  = 2'd0,
        KW_TRUE  = 2'd1,
        KW_FALSE = 2'd2
    } kw_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_flag;
    } in_word_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           token_kind;
        logic                 bool_value;
        logic [POS_WIDTH-1:0] line_number;
        logic [POS_WIDTH-1:0] column_number;
        logic                 last_of_run;
    } out_word_t;

    // Up to two result words per accepted byte, first one in w0
    typedef struct packed {
        logic      v0;
        out_word_t w0;
        logic      v1;
        out_word_t w1;
    } core_res_t;

    // Length of the literal's rest after its first letter
    function automatic logic [KW_POS_W-1:0] kw_len(input kw_t id);
        logic [KW_POS_W-1:0] len;
        case (id)
            KW_NULL:  len = KW_POS_W'(3);
            KW_TRUE:  len = KW_POS_W'(3);
            KW_FALSE: len = KW_POS_W'(4);
            default:  len = KW_POS_W'(0);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input kw_t id, input logic [KW_POS_W-1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (id)
            KW_NULL: begin
                case (pos)
                    KW_POS_W'(0): ch = CH_U;
                    KW_POS_W'(1): ch = CH_L;
                    KW_POS_W'(2): ch = CH_L;
                    default:      ch = 8'h00;
                endcase
            end
            KW_TRUE: begin
                case (pos)
                    KW_POS_W'(0): ch = CH_R;
                    KW_POS_W'(1): ch = CH_U;
                    KW_POS_W'(2): ch = CH_E;
                    default:      ch = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    KW_POS_W'(0): ch = CH_A;
                    KW_POS_W'(1): ch = CH_L;
                    KW_POS_W'(2): ch = CH_S;
                    KW_POS_W'(3): ch = CH_E;
                    default:      ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/jll_core.sv =====
// Lexer state, position counters and per-byte result logic.
module jll_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  jll_pkg::in_word_t  word,
    output jll_pkg::core_res_t res
);
    import jll_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    mode_t                mode_reg, mode_next;
    kw_t                  id_reg, id_next;
    logic [KW_POS_W-1:0]  pos_reg, pos_next;
    logic [POS_WIDTH-1:0] line_reg, line_next;
    logic [POS_WIDTH-1:0] col_reg, col_next;

    logic [7:0]           c;
    logic                 fin;
    logic                 blank;
    logic                 term;
    logic                 pos_ok;
    logic [POS_WIDTH-1:0] cons_line;
    logic [POS_WIDTH-1:0] cons_col;
    logic [KW_POS_W-1:0]  pos_inc;

    // idle-mode handling of the current symbol
    logic                 idle_v;
    out_word_t            idle_w;
    mode_t                idle_mode;
    kw_t                  idle_id;
    logic [POS_WIDTH-1:0] idle_line;
    logic [POS_WIDTH-1:0] idle_col;

    logic                 use_idle;
    logic                 tok_first;
    logic                 va;
    out_word_t            wa;
    out_word_t            tok_w;

    function automatic out_word_t make_word(
        input logic [1:0]           st,
        input logic [1:0]           kind,
        input logic                 bval,
        input logic [POS_WIDTH-1:0] ln,
        input logic [POS_WIDTH-1:0] cl
    );
        out_word_t w;
        w.status        = st;
        w.token_kind    = kind;
        w.bool_value    = bval;
        w.line_number   = ln;
        w.column_number = cl;
        w.last_of_run   = 1'b0;
        return w;
    endfunction

    assign c      = word.data_byte;
    assign fin    = word.end_flag;
    assign blank  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign term   = fin || blank || (c == CH_COLON) || (c == CH_COMMA)
                    || (c == CH_RBRK) || (c == CH_RBRC);
    assign pos_ok = pos_reg < kw_len(id_reg);
    assign pos_inc = pos_reg + KW_POS_W'(1);

    // Saturating position update for a consumed character
    always_comb
    begin
        cons_line = line_reg;
        cons_col  = col_reg;
        if (c == CH_LF)
        begin
            if (line_reg != POS_MAX)
                cons_line = line_reg + POS_WIDTH'(1);
            cons_col = '0;
        end
        else if (col_reg != POS_MAX)
        begin
            cons_col = col_reg + POS_WIDTH'(1);
        end
    end

    always_comb
    begin
        idle_v    = 1'b0;
        idle_w    = make_word(ST_END, KIND_NONE, 1'b0, line_reg, col_reg);
        idle_mode = MODE_IDLE;
        idle_id   = id_reg;
        idle_line = cons_line;
        idle_col  = cons_col;
        if (fin)
        begin
            idle_v    = 1'b1;
            idle_line = line_reg;
            idle_col  = col_reg;
        end
        else if (blank)
        begin
            idle_v = 1'b0;
        end
        else if (c == CH_N || c == CH_T || c == CH_F)
        begin
            idle_mode = MODE_MATCH;
            idle_id   = (c == CH_N) ? KW_NULL : ((c == CH_T) ? KW_TRUE : KW_FALSE);
        end
        else
        begin
            idle_v = 1'b1;
            idle_w = make_word(ST_UNEXP, KIND_NONE, 1'b0, cons_line, cons_col);
        end
    end

    assign tok_w = make_word(ST_OK, (id_reg == KW_NULL) ? KIND_NULL : KIND_BOOL,
                             id_reg == KW_TRUE, line_reg, col_reg);

    always_comb
    begin
        mode_next = mode_reg;
        id_next   = id_reg;
        pos_next  = pos_reg;
        line_next = line_reg;
        col_next  = col_reg;
        use_idle  = 1'b0;
        tok_first = 1'b0;
        va        = 1'b0;
        wa        = make_word(ST_UNEXP, KIND_NONE, 1'b0, line_reg, col_reg);
        res       = '0;

        case (mode_reg)
            MODE_MATCH:
            begin
                if (!pos_ok)
                begin
                    use_idle = 1'b1;
                end
                else if (fin)
                begin
                    mode_next = MODE_IDLE;
                    va        = 1'b1;
                end
                else
                begin
                    line_next = cons_line;
                    col_next  = cons_col;
                    if (c == kw_char(id_reg, pos_reg))
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= kw_len(id_reg))
                            mode_next = MODE_AWAIT;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        va        = 1'b1;
                        wa        = make_word(ST_UNEXP, KIND_NONE, 1'b0, cons_line, cons_col);
                    end
                end
            end
            MODE_AWAIT:
            begin
                if (term)
                begin
                    // token goes out first, terminator is then lexed as idle
                    tok_first = 1'b1;
                    use_idle  = 1'b1;
                end
                else
                begin
                    line_next = cons_line;
                    col_next  = cons_col;
                    mode_next = MODE_IDLE;
                    va        = 1'b1;
                    wa        = make_word(ST_UNEXP, KIND_NONE, 1'b0, cons_line, cons_col);
                end
            end
            default:
            begin
                use_idle = 1'b1;
            end
        endcase

        if (use_idle)
        begin
            mode_next = idle_mode;
            id_next   = idle_id;
            if (idle_mode == MODE_MATCH)
                pos_next = '0;
            line_next = idle_line;
            col_next  = idle_col;
        end

        if (tok_first)
        begin
            res.v0 = 1'b1;
            res.w0 = tok_w;
            res.v1 = idle_v;
            res.w1 = idle_w;
        end
        else if (use_idle)
        begin
            res.v0 = idle_v;
            res.w0 = idle_w;
        end
        else
        begin
            res.v0 = va;
            res.w0 = wa;
        end

        res.w0.last_of_run = !res.v1;
        res.w1.last_of_run = 1'b1;
        res.v0 = res.v0 && take;
        res.v1 = res.v1 && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            id_reg   <= KW_NULL;
            pos_reg  <= '0;
            line_reg <= '0;
            col_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            id_reg   <= id_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        res.v1 |-> (res.v0 && res.w0.status == ST_OK))
        else $error("second result word without a token word ahead of it");

    a_result_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        res.v0 |-> take)
        else $error("result word produced without an accepted byte");

    a_match_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_MATCH) |-> (pos_reg < kw_len(id_reg)))
        else $error("literal match position past the literal's end");

endmodule

// ===== hw/rtl/jll_outq.sv =====
// Four-word result queue that takes up to two words per cycle while not full and emits one while tok_stall is low.
module jll_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  jll_pkg::core_res_t  res,
    output logic                full,
    output logic                tok_valid,
    input  logic                tok_stall,
    output jll_pkg::out_word_t  tok_word
);
    import jll_pkg::*;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    out_word_t         q_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_reg, wr_next;
    logic [Q_AW-1:0]   rd_reg, rd_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;
    logic [Q_AW-1:0]   wr_second;
    logic              pop;
    logic [1:0]        n_push;

    assign wr_second = wr_reg + Q_AW'(1);
    assign pop       = tok_valid && !tok_stall;
    assign n_push    = {1'b0, res.v0} + {1'b0, res.v1};
    assign tok_valid = cnt_reg != '0;
    assign tok_word  = q_reg[rd_reg];
    // hold off input unless two free slots are guaranteed
    assign full      = cnt_reg > (Q_AW + 1)'(Q_DEPTH - 2);

    always_comb
    begin
        wr_next  = wr_reg + Q_AW'(n_push);
        rd_next  = pop ? rd_reg + Q_AW'(1) : rd_reg;
        cnt_next = cnt_reg + (Q_AW + 1)'(n_push) - (Q_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.v0)
            q_reg[wr_reg] <= res.w0;
        if (res.v1)
            q_reg[wr_second] <= res.w1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> (cnt_reg <= (Q_AW + 1)'(Q_DEPTH - 2)))
        else $error("result queue written while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (Q_AW + 1)'(Q_DEPTH))
        else $error("result queue count past its depth");

    a_stalled_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_stall) |=> (tok_valid && $stable(tok_word)))
        else $error("stalled result word changed or dropped");

endmodule

// ===== hw/rtl/json_literal_lexer_top.sv =====
// Top level of the JSON literal lexer: lexer core plus result queue.
//
//   channel  dir  handshake                 word
//   byte     in   byte_valid / byte_stall   data_byte, end_flag
//   tok      out  tok_valid / tok_stall     status, kind, bool, line, column, last
//
// One byte is taken per cycle while byte_stall is low; its results enter the queue
// on that edge; from an empty queue the first is offered on tok the next cycle. A
// byte can give two words (a token and what its terminator yields), drained one
// per unstalled cycle from a 4-word queue; byte_stall rises while it holds three
// or more. Reset clears mode, counters and the queue; no clearing pass is needed.
module json_literal_lexer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  jll_pkg::in_word_t  byte_word,
    output logic               tok_valid,
    input  logic               tok_stall,
    output jll_pkg::out_word_t tok_word
);
    import jll_pkg::*;

    logic      take;
    core_res_t res;

    assign take = byte_valid && !byte_stall;

    jll_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (byte_word),
        .res   (res)
    );

    jll_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .full      (byte_stall),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word)
    );

endmodule

// ===== bench/json_literal_lexer_top_tb.sv =====
// Self-checking bench for the JSON literal lexer top with randomized flow control.
module json_literal_lexer_top_tb;
    import jll_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 650;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_word_t  byte_word  = '0;
    logic      tok_valid;
    logic      tok_stall  = 1'b0;
    out_word_t tok_word;

    in_word_t    pending_bytes[$];
    out_word_t   expected_tokens[$];
    out_word_t   token_due;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          error_count   = 0;
    int          quiet_cycles  = 0;

    // Predictor state
    mode_t                lx_mode = MODE_IDLE;
    kw_t                  lx_kw   = KW_NULL;
    logic [2:0]           lx_pos  = '0;
    logic [POS_WIDTH-1:0] lx_line = '0;
    logic [POS_WIDTH-1:0] lx_col  = '0;

    json_literal_lexer_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_word   (tok_word)
    );

    always #5 clk = ~clk;

    function automatic string literal_tail(input kw_t id);
        string tail;
        case (id)
            KW_NULL:  tail = "ull";
            KW_TRUE:  tail = "rue";
            KW_FALSE: tail = "alse";
            default:  tail = "";
        endcase
        return tail;
    endfunction

    function automatic bit is_blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit is_terminator(input logic [7:0] c);
        return is_blank_char(c) || c == CH_COLON || c == CH_COMMA ||
               c == CH_RBRK || c == CH_RBRC;
    endfunction

    task automatic advance_position(input logic [7:0] c);
        if (c == CH_LF)
        begin
            if (lx_line != '1)
                lx_line = lx_line + 1'b1;
            lx_col = '0;
        end
        else if (lx_col != '1)
            lx_col = lx_col + 1'b1;
    endtask

    task automatic emit_word(input logic [1:0] st, input logic [1:0] kind, input logic bval);
        out_word_t w;
        w.status        = st;
        w.token_kind    = kind;
        w.bool_value    = bval;
        w.line_number   = lx_line;
        w.column_number = lx_col;
        w.last_of_run   = 1'b0;
        expected_tokens.push_back(w);
    endtask

    task automatic idle_symbol(input logic [7:0] c, input logic at_end);
        lx_mode = MODE_IDLE;
        if (at_end)
            emit_word(ST_END, KIND_NONE, 1'b0);
        else
        begin
            advance_position(c);
            if (c == CH_N || c == CH_T || c == CH_F)
            begin
                lx_mode = MODE_MATCH;
                lx_kw   = (c == CH_N) ? KW_NULL : (c == CH_T) ? KW_TRUE : KW_FALSE;
                lx_pos  = '0;
            end
            else if (!is_blank_char(c))
                emit_word(ST_UNEXP, KIND_NONE, 1'b0);
        end
    endtask

    // Work out the words that one accepted byte causes
    task automatic lex_byte(input in_word_t w);
        int        queued;
        string     tail;
        out_word_t tail_word;
        queued = expected_tokens.size();
        tail   = literal_tail(lx_kw);
        if (lx_mode == MODE_MATCH && lx_pos < tail.len())
        begin
            if (w.end_flag)
            begin
                lx_mode = MODE_IDLE;
                emit_word(ST_UNEXP, KIND_NONE, 1'b0);
            end
            else
            begin
                advance_position(w.data_byte);
                if (w.data_byte == tail[lx_pos])
                begin
                    lx_pos = lx_pos + 1'b1;
                    if (lx_pos >= tail.len())
                        lx_mode = MODE_AWAIT;
                end
                else
                begin
                    lx_mode = MODE_IDLE;
                    emit_word(ST_UNEXP, KIND_NONE, 1'b0);
                end
            end
        end
        else if (lx_mode == MODE_AWAIT)
        begin
            if (w.end_flag || is_terminator(w.data_byte))
            begin
                if (lx_kw == KW_NULL)
                    emit_word(ST_OK, KIND_NULL, 1'b0);
                else
                    emit_word(ST_OK, KIND_BOOL, lx_kw == KW_TRUE);
                // The terminator is handled again as a fresh symbol
                idle_symbol(w.data_byte, w.end_flag);
            end
            else
            begin
                advance_position(w.data_byte);
                lx_mode = MODE_IDLE;
                emit_word(ST_UNEXP, KIND_NONE, 1'b0);
            end
        end
        else
            idle_symbol(w.data_byte, w.end_flag);
        if (expected_tokens.size() > queued)
        begin
            tail_word = expected_tokens.pop_back();
            tail_word.last_of_run = 1'b1;
            expected_tokens.push_back(tail_word);
        end
    endtask

    task automatic push_char(input logic [7:0] c);
        in_word_t w;
        w.data_byte = c;
        w.end_flag  = 1'b0;
        pending_bytes.push_back(w);
    endtask

    task automatic push_end(input logic [7:0] junk);
        in_word_t w;
        w.data_byte = junk;
        w.end_flag  = 1'b1;
        pending_bytes.push_back(w);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_LF;
            default: c = CH_CR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        case ($urandom_range(7))
            0:       c = CH_COLON;
            1:       c = CH_COMMA;
            2:       c = CH_RBRK;
            3:       c = CH_RBRC;
            default: c = pick_blank();
        endcase
        return c;
    endfunction

    function automatic string pick_literal();
        string lit;
        case ($urandom_range(2))
            0:       lit = "null";
            1:       lit = "true";
            default: lit = "false";
        endcase
        return lit;
    endfunction

    task automatic add_random_chunk();
        int unsigned pick;
        int unsigned cut;
        string       lit;
        pick = $urandom_range(99);
        lit  = pick_literal();
        if (pick < 55)
        begin
            repeat ($urandom_range(2))
                push_char(pick_blank());
            push_text(lit);
            if ($urandom_range(19) == 0)
                push_end(8'($urandom_range(255)));
            else
                push_char(pick_terminator());
        end
        else if (pick < 65)
        begin
            repeat ($urandom_range(4, 1))
                push_char(pick_blank());
        end
        else if (pick < 75)
        begin
            // Break the literal off somewhere inside it
            cut = $urandom_range(lit.len() - 1, 1);
            push_text(lit.substr(0, cut - 1));
            if ($urandom_range(3) == 0)
                push_end(8'($urandom_range(255)));
            else
                push_char(8'($urandom_range(255)));
        end
        else if (pick < 85)
        begin
            push_text(lit);
            push_char(8'($urandom_range(255)));
        end
        else if (pick < 95)
            push_char(8'($urandom_range(255)));
        else
            push_end(8'($urandom_range(255)));
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // Driver: advance to the next word once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_word  <= '0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                lex_byte(byte_word);
            if (!byte_valid || !byte_stall)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_word  <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each taken word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_stall <= 1'b0;
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("word on tok with nothing predicted: %h", tok_word);
                    error_count++;
                end
                else
                begin
                    token_due = expected_tokens.pop_front();
                    check_field("status", 32'(token_due.status), 32'(tok_word.status));
                    check_field("token_kind", 32'(token_due.token_kind),
                                32'(tok_word.token_kind));
                    check_field("bool_value", 32'(token_due.bool_value),
                                32'(tok_word.bool_value));
                    check_field("line_number", 32'(token_due.line_number),
                                32'(tok_word.line_number));
                    check_field("column_number", 32'(token_due.column_number),
                                32'(tok_word.column_number));
                    check_field("last_of_run", 32'(token_due.last_of_run),
                                32'(tok_word.last_of_run));
                end
            end
            tok_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles where neither channel moves a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (tok_valid && !tok_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("json_literal_lexer_top test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_bytes_drained();
        while (pending_bytes.size() != 0 || byte_valid)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 48;
        // Directed: each literal with a terminator, end marker three times, broken literals
        push_text("null,");
        push_text("true\t");
        push_text("false");
        push_end(CH_N);
        push_end(8'hFF);
        push_text("n");
        push_end(8'h00);
        push_text("tx");
        push_text("nullx");
        push_text("false}\r\n");
        push_text("true]:");
        push_char(8'hFF);
        push_char(8'h00);
        while (pending_bytes.size() < PHASE_BYTES)
            add_random_chunk();
        wait_bytes_drained();

        send_idle_pct = 48;
        recv_idle_pct = 17;
        while (pending_bytes.size() < PHASE_BYTES)
            add_random_chunk();
        wait_bytes_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (pending_bytes.size() < PHASE_BYTES)
            add_random_chunk();
        push_text("false\nx");
        push_end(8'($urandom_range(255)));
        wait_bytes_drained();

        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("json_literal_lexer_top test passed");
        else
            $display("json_literal_lexer_top test failed");
        $finish;
    end

endmodule
